/* src/rne_pkg.sv */
// Shared types, constants and symbol functions of the Roman numeral encoder.
package rne_pkg;

    localparam int unsigned VALUE_W   = 12;
    localparam int unsigned SYM_W     = 8;
    localparam int unsigned MAX_VALUE = 3999;

    // ASCII codes of the numeral symbols.
    localparam logic [SYM_W-1:0] SYM_M    = 8'h4D;
    localparam logic [SYM_W-1:0] SYM_D    = 8'h44;
    localparam logic [SYM_W-1:0] SYM_C    = 8'h43;
    localparam logic [SYM_W-1:0] SYM_L    = 8'h4C;
    localparam logic [SYM_W-1:0] SYM_X    = 8'h58;
    localparam logic [SYM_W-1:0] SYM_V    = 8'h56;
    localparam logic [SYM_W-1:0] SYM_I    = 8'h49;
    localparam logic [SYM_W-1:0] SYM_NONE = 8'h00;

    // Decimal places of the value.
    localparam logic [1:0] PLACE_THOU = 2'd3;
    localparam logic [1:0] PLACE_HUND = 2'd2;
    localparam logic [1:0] PLACE_TENS = 2'd1;
    localparam logic [1:0] PLACE_ONES = 2'd0;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // take a new value and split off the thousands
        logic split_h;  // split off the hundreds
        logic split_t;  // split tens and ones, pick the first place
        logic emit;     // load one character into the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic err;       // value of the accepted beat is out of range
        logic last;      // character at the current position ends the numeral
        logic out_free;  // output register can take a character this cycle
    } t_sts;

    // Number of characters a digit produces.
    function automatic logic [2:0] rne_len(input logic [3:0] d);
        logic [2:0] n;
        case (d)
            4'd0:    n = 3'd0;
            4'd1:    n = 3'd1;
            4'd2:    n = 3'd2;
            4'd3:    n = 3'd3;
            4'd4:    n = 3'd2;
            4'd5:    n = 3'd1;
            4'd6:    n = 3'd2;
            4'd7:    n = 3'd3;
            4'd8:    n = 3'd4;
            4'd9:    n = 3'd2;
            default: n = 3'd0;
        endcase
        return n;
    endfunction

    // Character at a given step of a digit in a given place.
    function automatic logic [SYM_W-1:0] rne_sym(input logic [3:0] d,
                                                input logic [1:0] step,
                                                input logic [1:0] place);
        logic [SYM_W-1:0] one;
        logic [SYM_W-1:0] five;
        logic [SYM_W-1:0] ten;
        logic [SYM_W-1:0] s;
        case (place)
            PLACE_THOU: begin
                one = SYM_M; five = SYM_NONE; ten = SYM_NONE;
            end
            PLACE_HUND: begin
                one = SYM_C; five = SYM_D; ten = SYM_M;
            end
            PLACE_TENS: begin
                one = SYM_X; five = SYM_L; ten = SYM_C;
            end
            default: begin
                one = SYM_I; five = SYM_V; ten = SYM_X;
            end
        endcase
        // Nine and four use the subtractive pair, five to eight lead with five.
        if (d == 4'd9) begin
            s = (step == 2'd0) ? one : ten;
        end else if (d >= 4'd5) begin
            s = (step == 2'd0) ? five : one;
        end else if (d == 4'd4) begin
            s = (step == 2'd0) ? one : five;
        end else begin
            s = one;
        end
        return s;
    endfunction

endpackage

/* src/rne_ctrl.sv */
// Controller state machine of the Roman numeral encoder.
module rne_ctrl
    import rne_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SPLIT_H,
        ST_SPLIT_T,
        ST_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    // Commands follow the state; emission waits for a free output register.
    always_comb begin
        o_cmd         = '0;
        o_cmd.load    = w_accept;
        o_cmd.split_h = (r_state == ST_SPLIT_H);
        o_cmd.split_t = (r_state == ST_SPLIT_T);
        o_cmd.emit    = (r_state == ST_EMIT) && i_sts.out_free;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = i_sts.err ? ST_EMIT : ST_SPLIT_H;
                end
            end
            ST_SPLIT_H: n_state = ST_SPLIT_T;
            ST_SPLIT_T: n_state = ST_EMIT;
            ST_EMIT: begin
                if (o_cmd.emit && i_sts.last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* src/rne_datapath.sv */
// Digit splitting, symbol selection and output register of the encoder.
module rne_datapath
    import rne_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [VALUE_W-1:0] i_value,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic [SYM_W-1:0]   o_symbol,
    output logic               o_last,
    output logic               o_oor
);

    // Digit and position registers.
    logic             r_err;
    logic [9:0]       r_rem;
    logic [1:0]       r_d3;
    logic [3:0]       r_d2;
    logic [3:0]       r_d1;
    logic [3:0]       r_d0;
    logic [1:0]       r_place;
    logic [1:0]       r_step;
    // Output register.
    logic             r_out_valid;
    logic [SYM_W-1:0] r_symbol;
    logic             r_last;
    logic             r_oor;

    logic             w_err_in;
    logic [1:0]       w_th;
    logic [VALUE_W-1:0] w_rem_th;
    logic [3:0]       w_hu;
    logic [9:0]       w_rem_hu;
    logic [3:0]       w_te;
    logic [6:0]       w_rem_te;
    logic [3:0]       w_cur_d;
    logic [2:0]       w_cur_len;
    logic             w_digit_end;
    logic             w_lower_zero;
    logic [1:0]       w_next_place;
    logic [1:0]       w_first_place;
    logic             w_cur_last;
    logic [SYM_W-1:0] w_cur_sym;

    // Range check and thousands split on the incoming value.
    always_comb begin
        w_err_in = (i_value == '0) || (i_value > VALUE_W'(MAX_VALUE));
        if (i_value >= VALUE_W'(3000)) begin
            w_th = 2'd3;
        end else if (i_value >= VALUE_W'(2000)) begin
            w_th = 2'd2;
        end else if (i_value >= VALUE_W'(1000)) begin
            w_th = 2'd1;
        end else begin
            w_th = 2'd0;
        end
        w_rem_th = i_value - VALUE_W'(w_th) * VALUE_W'(1000);
    end

    // Hundreds split: the largest multiple of one hundred not above the rest.
    always_comb begin
        w_hu = 4'd0;
        for (int k = 1; k <= 9; k++) begin
            if (r_rem >= 10'(k * 100)) begin
                w_hu = 4'(k);
            end
        end
        w_rem_hu = r_rem - 10'(w_hu) * 10'd100;
    end

    // Tens split; the ones are what is left.
    always_comb begin
        w_te = 4'd0;
        for (int k = 1; k <= 9; k++) begin
            if (r_rem[6:0] >= 7'(k * 10)) begin
                w_te = 4'(k);
            end
        end
        w_rem_te = r_rem[6:0] - 7'(w_te) * 7'd10;
    end

    // First place with a nonzero digit once the split is done.
    always_comb begin
        if (r_d3 != 2'd0) begin
            w_first_place = PLACE_THOU;
        end else if (r_d2 != 4'd0) begin
            w_first_place = PLACE_HUND;
        end else if (w_te != 4'd0) begin
            w_first_place = PLACE_TENS;
        end else begin
            w_first_place = PLACE_ONES;
        end
    end

    // Digit at the current place and what follows it.
    always_comb begin
        case (r_place)
            PLACE_THOU: begin
                w_cur_d      = {2'b00, r_d3};
                w_lower_zero = (r_d2 == 4'd0) && (r_d1 == 4'd0) && (r_d0 == 4'd0);
                w_next_place = (r_d2 != 4'd0) ? PLACE_HUND :
                               (r_d1 != 4'd0) ? PLACE_TENS : PLACE_ONES;
            end
            PLACE_HUND: begin
                w_cur_d      = r_d2;
                w_lower_zero = (r_d1 == 4'd0) && (r_d0 == 4'd0);
                w_next_place = (r_d1 != 4'd0) ? PLACE_TENS : PLACE_ONES;
            end
            PLACE_TENS: begin
                w_cur_d      = r_d1;
                w_lower_zero = (r_d0 == 4'd0);
                w_next_place = PLACE_ONES;
            end
            default: begin
                w_cur_d      = r_d0;
                w_lower_zero = 1'b1;
                w_next_place = PLACE_ONES;
            end
        endcase
        w_cur_len   = rne_len(w_cur_d);
        w_digit_end = ({1'b0, r_step} + 3'd1) >= w_cur_len;
        w_cur_last  = r_err || (w_digit_end && w_lower_zero);
        w_cur_sym   = r_err ? SYM_NONE : rne_sym(w_cur_d, r_step, r_place);
    end

    assign o_sts.err      = w_err_in;
    assign o_sts.last     = w_cur_last;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    // Digit and position registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_err <= w_err_in;
            r_d3  <= w_th;
            r_rem <= w_rem_th[9:0];
        end
        if (i_cmd.split_h) begin
            r_d2  <= w_hu;
            r_rem <= w_rem_hu;
        end
        if (i_cmd.split_t) begin
            r_d1    <= w_te;
            r_d0    <= w_rem_te[3:0];
            r_place <= w_first_place;
            r_step  <= 2'd0;
        end
        if (i_cmd.emit) begin
            if (w_digit_end) begin
                r_place <= w_next_place;
                r_step  <= 2'd0;
            end else begin
                r_step <= r_step + 2'd1;
            end
        end
    end

    // Output register: holds a beat until the sink takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.emit) begin
            r_symbol <= w_cur_sym;
            r_last   <= w_cur_last;
            r_oor    <= r_err;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_symbol    = r_symbol;
    assign o_last      = r_last;
    assign o_oor       = r_oor;

endmodule

/* src/roman_numeral_encoder.sv */
// Top level of the Roman numeral encoder: controller plus datapath.
//
//  Channel   Direction  Payload
//  s_axis    in         tdata[11:0] value (tdata[15:12] zero)
//  m_axis    out        tdata symbol, tlast last, tuser out_of_range
//
// The accept cycle splits off the thousands, SPLIT_H the hundreds and
// SPLIT_T the tens and ones; then the 1 to 15 characters of the numeral
// go into the output register one per cycle, while a stalled sink holds
// that register and pauses emission. An out-of-range value skips the
// splits and gives one zero symbol. s_axis_tready is high only between
// numerals. Reset is synchronous, active low, and returns to idle.
module roman_numeral_encoder
    import rne_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [11:0] value, [15:12] zero fill
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] symbol
    output logic        m_axis_tlast,
    output logic [0:0]  m_axis_tuser    // [0] out_of_range
);

    t_cmd w_cmd;
    t_sts w_sts;

    rne_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    rne_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_value     (s_axis_tdata[VALUE_W-1:0]),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_symbol    (m_axis_tdata),
        .o_last      (m_axis_tlast),
        .o_oor       (m_axis_tuser[0])
    );

endmodule

/* src/rne_checker.sv */
// Port-level checks of the Roman numeral encoder, bound to the top level.
module rne_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic        m_axis_tlast,
    input logic [0:0]  m_axis_tuser
);

    // An out-of-range beat is a lone zero symbol that ends its numeral.
    a_err_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast && (m_axis_tdata == 8'h00))
        else $error("out-of-range beat malformed");

    // A valid numeral never carries a zero symbol.
    a_sym_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> (m_axis_tdata != 8'h00))
        else $error("zero symbol in numeral");

    // No new value is taken in the cycle after one was accepted.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while converting");

    // A stalled output beat holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output beat changed under stall");

endmodule

bind roman_numeral_encoder rne_checker u_rne_checker (.*);

/* sim/tb_top.sv */
// Self-checking testbench of the Roman numeral encoder stream block.
`timescale 1ns / 100ps

module tb_top
    import rne_pkg::*;
();

    localparam int unsigned CLK_PERIOD   = 10;
    localparam int unsigned RESET_CYCLES = 7;
    localparam int unsigned LIMIT_CYCLES = 200000;
    localparam int unsigned TAIL_CYCLES  = 20;
    localparam int unsigned IDLE_PCT     = 13;

    // One expected output character.
    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             is_last;
        logic             out_of_range;
    } t_numeral_char;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // [11:0] value, [15:12] zero fill
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;   // [7:0] symbol
    logic        m_axis_tlast;
    logic [0:0]  m_axis_tuser;   // [0] out_of_range

    t_numeral_char    expected_chars[$];
    logic [SYM_W-1:0] numeral_syms[$];

    int unsigned n_errors;
    int unsigned n_values;
    int unsigned n_out_of_range;
    int unsigned n_chars_seen;
    int unsigned cycle_count;
    int unsigned stall_request;
    bit          tx_idle_on;
    bit          rx_idle_on;

    roman_numeral_encoder DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Appends the symbols of one decimal digit in the given place.
    function automatic void append_digit(input int unsigned d,
                                         input logic [SYM_W-1:0] one,
                                         input logic [SYM_W-1:0] five,
                                         input logic [SYM_W-1:0] ten);
        int unsigned k;
        if (d == 9) begin
            numeral_syms.push_back(one);
            numeral_syms.push_back(ten);
        end else if (d >= 5) begin
            numeral_syms.push_back(five);
            for (k = 5; k < d; k++) numeral_syms.push_back(one);
        end else if (d == 4) begin
            numeral_syms.push_back(one);
            numeral_syms.push_back(five);
        end else begin
            for (k = 0; k < d; k++) numeral_syms.push_back(one);
        end
    endfunction

    // Works out the characters of one numeral and queues them for checking.
    function automatic void predict_numeral(input logic [VALUE_W-1:0] value);
        int unsigned   v;
        int unsigned   k;
        t_numeral_char c;
        v = value;
        numeral_syms.delete();
        if (v == 0 || v > MAX_VALUE) begin
            c.symbol       = SYM_NONE;
            c.is_last      = 1'b1;
            c.out_of_range = 1'b1;
            expected_chars.push_back(c);
            n_out_of_range++;
        end else begin
            for (k = 0; k < v / 1000; k++) numeral_syms.push_back(SYM_M);
            append_digit((v / 100) % 10, SYM_C, SYM_D, SYM_M);
            append_digit((v / 10) % 10, SYM_X, SYM_L, SYM_C);
            append_digit(v % 10, SYM_I, SYM_V, SYM_X);
            for (k = 0; k < numeral_syms.size(); k++) begin
                c.symbol       = numeral_syms[k];
                c.is_last      = (k == numeral_syms.size() - 1);
                c.out_of_range = 1'b0;
                expected_chars.push_back(c);
            end
        end
    endfunction

    // Picks a random value: mostly in range, some long numerals, some errors.
    function automatic logic [VALUE_W-1:0] random_value();
        int unsigned r;
        int unsigned v;
        int unsigned k;
        r = $urandom_range(99);
        if (r < 12) begin
            v = ($urandom_range(7) == 0) ? 0 : $urandom_range(4095, MAX_VALUE + 1);
        end else if (r < 27) begin
            // Digits biased toward the longest forms.
            v = $urandom_range(3);
            for (k = 0; k < 3; k++) begin
                case ($urandom_range(3))
                    0:       v = v * 10 + 3;
                    1:       v = v * 10 + 7;
                    2:       v = v * 10 + 8;
                    default: v = v * 10 + $urandom_range(9);
                endcase
            end
            if (v == 0) v = 8;
        end else begin
            v = $urandom_range(MAX_VALUE, 1);
        end
        return v[VALUE_W-1:0];
    endfunction

    // Offers one value at the input and returns once the beat is taken.
    task automatic send_value(input logic [VALUE_W-1:0] value);
        @(negedge i_clk);
        if (tx_idle_on) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                s_axis_tvalid = 1'b0;
                @(negedge i_clk);
            end
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {4'b0000, value};
        do @(posedge i_clk); while (!s_axis_tready);
        predict_numeral(value);
        n_values++;
    endtask

    // Stops offering input.
    task automatic stop_sending();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    // Waits until every queued character has come out.
    task automatic wait_drained();
        while (expected_chars.size() != 0) @(posedge i_clk);
    endtask

    // Sink side: random stalls plus long hold-offs on request.
    initial begin : sink_ready
        int unsigned stall_left;
        stall_left    = 0;
        m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (stall_request != 0) begin
                stall_left    = stall_request;
                stall_request = 0;
            end
            if (stall_left != 0) begin
                m_axis_tready = 1'b0;
                stall_left--;
            end else begin
                m_axis_tready = !(rx_idle_on && ($urandom_range(99) < IDLE_PCT));
            end
        end
    end

    // Compares each output beat with the oldest expected character.
    always @(posedge i_clk) begin
        t_numeral_char c;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_chars_seen++;
            if (expected_chars.size() == 0) begin
                $error("unexpected output beat: symbol 0x%02h last %0b out_of_range %0b",
                       m_axis_tdata, m_axis_tlast, m_axis_tuser[0]);
                n_errors++;
            end else begin
                c = expected_chars.pop_front();
                if (m_axis_tdata !== c.symbol) begin
                    $error("symbol: expected 0x%02h, got 0x%02h", c.symbol, m_axis_tdata);
                    n_errors++;
                end
                if (m_axis_tlast !== c.is_last) begin
                    $error("last: expected %0b, got %0b", c.is_last, m_axis_tlast);
                    n_errors++;
                end
                if (m_axis_tuser[0] !== c.out_of_range) begin
                    $error("out_of_range: expected %0b, got %0b",
                           c.out_of_range, m_axis_tuser[0]);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Range limits, every digit form in the ones place, and the longest numeral.
    task automatic test_directed_values();
        int unsigned vals[$];
        vals = '{1, 3999, 0, 4000, 4095, 3888, 4, 9, 5, 6, 7, 8, 2, 3,
                 40, 90, 400, 900, 1000, 2000, 3000, 1994, 2730, 444, 999};
        foreach (vals[k]) send_value(vals[k][VALUE_W-1:0]);
        stop_sending();
        wait_drained();
    endtask

    // Random values with idling on both sides.
    task automatic test_random_values(input int unsigned count);
        int unsigned k;
        for (k = 0; k < count; k++) send_value(random_value());
    endtask

    // Back-to-back values with no idling at all.
    task automatic test_no_idle_stretch(input int unsigned count);
        int unsigned k;
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        for (k = 0; k < count; k++) send_value(random_value());
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // Sink holds off for a long time while values keep coming.
    task automatic test_output_backpressure(input int unsigned count);
        int unsigned k;
        stall_request = 300;
        for (k = 0; k < count; k++) begin
            send_value((k % 3 == 0) ? 12'd3888 : random_value());
        end
    endtask

    // Source stops until every pending character has come out, then resumes.
    task automatic test_pause_until_drained(input int unsigned count);
        int unsigned k;
        for (k = 0; k < count; k++) begin
            send_value(random_value());
            stop_sending();
            wait_drained();
        end
    endtask

    // Test sequence.
    initial begin
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        n_errors       = 0;
        n_values       = 0;
        n_out_of_range = 0;
        n_chars_seen   = 0;
        cycle_count    = 0;
        stall_request  = 0;
        tx_idle_on     = 1'b1;
        rx_idle_on     = 1'b1;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_values();
        test_random_values(60);
        test_no_idle_stretch(35);
        test_output_backpressure(12);
        test_random_values(40);
        test_pause_until_drained(6);

        stop_sending();
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d values (%0d out of range), checked %0d output characters.",
                 n_values, n_out_of_range, n_chars_seen);
        $display("Covered directed edge values, random traffic, a long sink stall ",
                 "and a full drain pause.");
        if (n_errors == 0 && expected_chars.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
